// ===== hdl/spm_pkg.sv =====
// Shared types and constants for the stream pattern masker.
// Used by the top level, the front and the back; no dependencies.
package spm_pkg;

  localparam logic [7:0] ASTERISK = 8'd42;

  // Configuration register map.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  // Jobs held between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int JOB_CNT_W   = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  // One job: copy the first num_copy bytes, then num_star asterisks.
  typedef struct packed {
    logic [JOB_CNT_W-1:0] num_copy;
    logic [JOB_CNT_W-1:0] num_star;
    logic                 flush;
  } job_ctl_t;

endpackage

// ===== hdl/stream_pattern_masker_unit.sv =====
// Top level of the stream pattern masker: configuration registers, front,
// job queue and back. Depends on spm_pkg, spm_front, spm_queue, spm_back.
//
// Copies a byte stream to the output, replacing each leftmost,
// non-overlapping occurrence of the configured pattern (1 to 8 bytes) with
// as many '*' bytes. Up to pattern-length minus one bytes are held back;
// an item with stream_end set flushes them. The front takes one item per
// cycle while the queue has room, turning it into a job of zero to eight
// results; a four-entry job queue feeds the back, which registers one
// result per cycle into its output unless the output stalls. Input items
// flow at one per cycle as long as each gives at most one result and the
// output does not stall; the input stalls once the job queue is full.
// Items that give no result take no queue slot.
module stream_pattern_masker_unit #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spm_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output spm_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [spm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import spm_pkg::*;

  localparam int WINDOW_DEPTH = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int JOB_W        = $bits(job_ctl_t) + WINDOW_DEPTH * 8;

  logic [63:0]                   pattern_bytes;
  logic [3:0]                    pattern_length;
  logic                          push;
  logic                          full;
  logic                          pop;
  logic                          not_empty;
  job_ctl_t                      push_ctl;
  job_ctl_t                      head_ctl;
  logic [WINDOW_DEPTH*8-1:0]     push_bytes;
  logic [WINDOW_DEPTH*8-1:0]     head_bytes;
  logic [JOB_W-1:0]              head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_bytes  <= cfg_data[63:0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  spm_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .pattern_bytes (pattern_bytes),
    .pattern_length(pattern_length),
    .full          (full),
    .push          (push),
    .job_ctl       (push_ctl),
    .job_bytes     (push_bytes)
  );

  spm_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_ctl, push_bytes}),
    .full     (full),
    .pop      (pop),
    .pop_data (head_job),
    .not_empty(not_empty)
  );

  assign head_ctl   = head_job[JOB_W-1 -: $bits(job_ctl_t)];
  assign head_bytes = head_job[WINDOW_DEPTH*8-1:0];

  spm_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(not_empty),
    .job_ctl  (head_ctl),
    .job_bytes(head_bytes),
    .job_pop  (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// ===== hdl/spm_front.sv =====
// Front part: holds the pending window, matches it against the pattern and
// turns each accepted item with results into a job. Depends on spm_pkg.
module spm_front #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  spm_pkg::in_item_t             in_item,
  input  logic [63:0]                   pattern_bytes,
  input  logic [3:0]                    pattern_length,
  input  logic                          full,
  output logic                          push,
  output spm_pkg::job_ctl_t             job_ctl,
  output logic [WINDOW_DEPTH*8-1:0]     job_bytes
);
  import spm_pkg::*;

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [7:0]    window [WINDOW_DEPTH];
  logic [7:0]    window_next [WINDOW_DEPTH];
  logic [7:0]    seq [WINDOW_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] eff_len;
  logic [SW-1:0] total;
  logic [SW-1:0] shrink;
  logic [SW-1:0] num_copy;
  logic [SW-1:0] num_star;
  logic          full_window;
  logic          match;
  logic          accept;

  assign accept   = in_valid && !full;
  assign in_stall = full;

  always_comb begin
    if (pattern_length == 4'd0) begin
      eff_len = CW'(1);
    end else if (32'(pattern_length) > WINDOW_DEPTH) begin
      eff_len = CW'(WINDOW_DEPTH);
    end else begin
      eff_len = pattern_length[CW-1:0];
    end
  end

  // Pending bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      seq[i] = (in_item.byte_present && count == CW'(i)) ? in_item.data_byte : window[i];
    end
  end

  always_comb begin
    total  = SW'(count) + SW'(in_item.byte_present);
    // after a length shrink the oldest bytes go out unchanged
    shrink = (in_item.byte_present && count >= eff_len) ?
             SW'(count) - SW'(eff_len) + SW'(1) : '0;
    full_window = in_item.byte_present && (total - shrink == SW'(eff_len));

    match = 1'b1;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (SW'(k) < SW'(eff_len)) begin
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
          if (SW'(j) == shrink + SW'(k) && seq[j] != pattern_bytes[8*k +: 8]) begin
            match = 1'b0;
          end
        end
      end
    end

    if (full_window && match) begin
      num_copy = shrink;
      num_star = SW'(eff_len);
    end else if (in_item.stream_end) begin
      num_copy = total;
      num_star = '0;
    end else if (full_window) begin
      num_copy = shrink + SW'(1);
      num_star = '0;
    end else begin
      num_copy = shrink;
      num_star = '0;
    end

    if (in_item.stream_end || (full_window && match)) begin
      count_next = '0;
    end else begin
      count_next = CW'(total - num_copy);
    end

    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      window_next[i] = seq[i];
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        if (SW'(j) == SW'(i) + num_copy) begin
          window_next[i] = seq[j];
        end
      end
    end
  end

  assign push             = accept && (num_copy != '0 || num_star != '0);
  assign job_ctl.num_copy = JOB_CNT_W'(num_copy);
  assign job_ctl.num_star = JOB_CNT_W'(num_star);
  assign job_ctl.flush    = in_item.stream_end;

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      job_bytes[8*i +: 8] = seq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

endmodule

// ===== hdl/spm_queue.sv =====
// Small register FIFO of jobs between the front and the back.
// No package dependencies.
module spm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;

  assign full      = (fill == FW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/spm_back.sv =====
// Back part: plays out the job at the queue head one result per cycle into
// the output register while the output does not stall. Depends on spm_pkg.
module spm_back #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  spm_pkg::job_ctl_t         job_ctl,
  input  logic [WINDOW_DEPTH*8-1:0] job_bytes,
  output logic                      job_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output spm_pkg::out_item_t        out_item
);
  import spm_pkg::*;

  logic [JOB_CNT_W-1:0] idx;
  logic [JOB_CNT_W-1:0] total;
  logic                 last;
  logic                 advance;
  logic [7:0]           sel_byte;

  assign total   = job_ctl.num_copy + job_ctl.num_star;
  assign last    = (idx == total - JOB_CNT_W'(1));
  assign advance = job_valid && (!out_valid || !out_stall);
  assign job_pop = advance && last;

  always_comb begin
    sel_byte = ASTERISK;
    if (idx < job_ctl.num_copy) begin
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        if (idx == JOB_CNT_W'(j)) begin
          sel_byte = job_bytes[8*j +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx       <= last ? '0 : idx + JOB_CNT_W'(1);
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.out_byte    <= sel_byte;
      out_item.run_last    <= last;
      out_item.stream_done <= last && job_ctl.flush;
    end
  end

endmodule
